// ===== rtl/rms_pkg.sv =====
// Shared types, widths and controller/datapath interface for the record merge sorter.
`default_nettype none
package rms_pkg;

  localparam int KEY_BITS  = 16;
  localparam int TAG_BITS  = 8;
  localparam int DEPTH_DEF = 16;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    logic                last;
  } rms_in_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] sorted_key;
    logic [TAG_BITS-1:0] sorted_tag;
    logic                final_res;
  } rms_out_t;

  // one stored record
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } rec_t;

  localparam int REC_BITS = $bits(rec_t);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic merge_init;
    logic cap_a;
    logic cap_b;
    logic step;
    logic next;
    logic out_rd;
    logic out_ld;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic b_has;
    logic refill_a;
    logic refill_b;
    logic merge_last;
    logic more_merges;
    logic sorted;
    logic out_free;
    logic out_final;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/rms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/rms_ctrl.sv =====
// Sequencer for load, bottom-up merge passes and result read-out.
`default_nettype none
module rms_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  input  wire rms_pkg::stat_t stat,
  output rms_pkg::cmd_t      cmd
);
  import rms_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_PASS     = 11'b000_0000_0010,
    S_MINIT    = 11'b000_0000_0100,
    S_HEAD_A   = 11'b000_0000_1000,
    S_HEAD_B   = 11'b000_0001_0000,
    S_STEP     = 11'b000_0010_0000,
    S_REFILL_A = 11'b000_0100_0000,
    S_REFILL_B = 11'b000_1000_0000,
    S_NEXT     = 11'b001_0000_0000,
    S_OUT_RD   = 11'b010_0000_0000,
    S_OUT_LD   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.start = 1'b1;
            state_nxt = S_PASS;
          end
        end
      end
      S_PASS: begin
        state_nxt = stat.sorted ? S_OUT_RD : S_MINIT;
      end
      S_MINIT: begin
        cmd.merge_init = 1'b1;
        state_nxt      = S_HEAD_A;
      end
      S_HEAD_A: begin
        cmd.cap_a = 1'b1;
        state_nxt = stat.b_has ? S_HEAD_B : S_STEP;
      end
      S_HEAD_B: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (stat.merge_last) begin
          state_nxt = S_NEXT;
        end else if (stat.refill_a) begin
          state_nxt = S_REFILL_A;
        end else if (stat.refill_b) begin
          state_nxt = S_REFILL_B;
        end
      end
      S_REFILL_A: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_STEP;
      end
      S_REFILL_B: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_STEP;
      end
      S_NEXT: begin
        cmd.next  = 1'b1;
        state_nxt = stat.more_merges ? S_MINIT : S_PASS;
      end
      S_OUT_RD: begin
        if (stat.out_free) begin
          cmd.out_rd = 1'b1;
          state_nxt  = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        cmd.out_ld = 1'b1;
        state_nxt  = stat.out_final ? S_IDLE : S_OUT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/rms_dp.sv =====
// Datapath: two record banks, merge indices, run heads and the output register.
`default_nettype none
module rms_dp #(
  parameter int DEPTH = rms_pkg::DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rms_pkg::cmd_t    cmd,
  output rms_pkg::stat_t        stat,
  input  wire rms_pkg::rms_in_t in_data,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output rms_pkg::rms_out_t     out_data
);
  import rms_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH) + 3;

  logic [CW-1:0] n_r, o_r;
  logic [PW-1:0] w_r, lo_r, mid_r, hi_r, a_r, b_r, c_r;
  logic          src_r;
  rec_t          head_a_r, head_b_r;
  rms_out_t      out_r;
  logic          out_valid_r;

  logic [PW-1:0] n_w, lo_w, lo_2w, mid_calc, hi_calc, a_inc, b_inc, c_inc;
  logic          a_more, b_more, take_a, full;
  rec_t          rd0, rd1, rdata, pick, in_rec;
  logic [AW-1:0] raddr, waddr0, waddr1;
  logic          we0, we1;
  rec_t          wdata0;

  assign n_w      = PW'(n_r);
  assign lo_w     = lo_r + w_r;
  assign lo_2w    = lo_r + (w_r << 1);
  assign mid_calc = (lo_w < n_w) ? lo_w : n_w;
  assign hi_calc  = (lo_2w < n_w) ? lo_2w : n_w;
  assign a_inc    = a_r + PW'(1);
  assign b_inc    = b_r + PW'(1);
  assign c_inc    = c_r + PW'(1);
  assign a_more   = a_r < mid_r;
  assign b_more   = b_r < hi_r;
  // left run wins ties
  assign take_a   = a_more && (!b_more || (head_a_r.key <= head_b_r.key));
  assign pick     = take_a ? head_a_r : head_b_r;
  assign full     = (n_r == CW'(DEPTH));
  assign in_rec   = '{key: in_data.key, tag: in_data.tag};
  assign rdata    = src_r ? rd1 : rd0;

  always_comb begin
    stat             = '0;
    stat.b_has       = b_more;
    stat.refill_a    = take_a && (a_inc < mid_r);
    stat.refill_b    = !take_a && (b_inc < hi_r);
    stat.merge_last  = (c_inc == hi_r);
    stat.more_merges = (lo_2w < n_w);
    stat.sorted      = (w_r >= n_w);
    stat.out_free    = !out_valid_r || out_ready;
    stat.out_final   = ((o_r + CW'(1)) == n_r);
  end

  always_comb begin
    raddr = '0;
    if (cmd.merge_init) begin
      raddr = lo_r[AW-1:0];
    end else if (cmd.cap_a) begin
      raddr = b_r[AW-1:0];
    end else if (cmd.step) begin
      raddr = take_a ? a_inc[AW-1:0] : b_inc[AW-1:0];
    end else if (cmd.out_rd) begin
      raddr = o_r[AW-1:0];
    end
  end

  // bank 0 takes loads and merge output when bank 1 is the source
  assign we0    = (cmd.load && !full) || (cmd.step && src_r);
  assign waddr0 = cmd.load ? n_r[AW-1:0] : c_r[AW-1:0];
  assign wdata0 = cmd.load ? in_rec : pick;
  assign we1    = cmd.step && !src_r;
  assign waddr1 = c_r[AW-1:0];

  rms_ram #(.WIDTH(REC_BITS), .DEPTH(DEPTH)) u_bank0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr0),
    .wdata   (wdata0),
    .raddr   (raddr),
    .rd_data (rd0)
  );

  rms_ram #(.WIDTH(REC_BITS), .DEPTH(DEPTH)) u_bank1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr1),
    .wdata   (pick),
    .raddr   (raddr),
    .rd_data (rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      o_r         <= '0;
      w_r         <= '0;
      lo_r        <= '0;
      src_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && !full) begin
        n_r <= n_r + CW'(1);
      end
      if (cmd.start) begin
        w_r   <= PW'(1);
        lo_r  <= '0;
        src_r <= 1'b0;
        o_r   <= '0;
      end
      if (cmd.next) begin
        if (lo_2w < n_w) begin
          lo_r <= lo_2w;
        end else begin
          w_r   <= w_r << 1;
          lo_r  <= '0;
          src_r <= !src_r;
        end
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
        if (stat.out_final) begin
          n_r <= '0;
          o_r <= '0;
        end else begin
          o_r <= o_r + CW'(1);
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.merge_init) begin
      mid_r <= mid_calc;
      hi_r  <= hi_calc;
      a_r   <= lo_r;
      b_r   <= mid_calc;
      c_r   <= lo_r;
    end
    if (cmd.step) begin
      c_r <= c_inc;
      if (take_a) begin
        a_r <= a_inc;
      end else begin
        b_r <= b_inc;
      end
    end
    if (cmd.cap_a) begin
      head_a_r <= rdata;
    end
    if (cmd.cap_b) begin
      head_b_r <= rdata;
    end
    if (cmd.out_ld) begin
      out_r.sorted_key <= rdata.key;
      out_r.sorted_tag <= rdata.tag;
      out_r.final_res  <= stat.out_final;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/record_merge_sort_core.sv =====
// Load: requests are accepted while the sequencer is idle; the request with last then starts the sort.
// Sort: bottom-up merge passes over two ping-pong RAM banks with one read port each,
//   each step writing one merged record and refilling the run head that it took.
// Read-out: each result takes a RAM read, then an output register load; a stall holds it.
// Sets: one at a time; the single RAM read port per bank sets the sort and read-out pace.
// Reset: synchronous, active low; clears the count, the sequencer and the output valid.
`default_nettype none
module record_merge_sort_core #(
  parameter int DEPTH = rms_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rms_pkg::rms_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rms_pkg::rms_out_t      out_data
);
  import rms_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: load requests, step merges, drain results.
  rms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: records held in two banks; each pass reads one and writes the other.
  // Records past the store depth are dropped, the count holding at DEPTH.
  rms_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Never overwrite a result still waiting downstream.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !out_valid)
    else $error("result register loaded while still occupied");

  // A last request closes the input until the set has drained.
  a_last_closes : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last) |=> !in_ready)
    else $error("input still open after last request");

  // Load, sort and read-out commands are mutually exclusive.
  a_cmd_excl : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.merge_init, cmd.cap_a, cmd.cap_b, cmd.step, cmd.next,
              cmd.out_rd, cmd.out_ld, cmd.load}))
    else $error("conflicting datapath commands");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for record_merge_sort_core: sets must return in stable key order.
module testbench;
  import rms_pkg::*;

  // Store size of the block under test, at its default parameter value.
  localparam int STORE_DEPTH = DEPTH_DEF;
  // Quiet cycles after the last result, to catch stray output from a late read-out.
  localparam int SETTLE_CYCLES = 64;

  // How the random key of a set is drawn: a narrow range forces many equal keys.
  typedef enum int {
    KEYS_NARROW,
    KEYS_EXTREME,
    KEYS_WIDE
  } key_spread_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  rms_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rms_out_t out_data;

  // Idle rates in percent: the chance of a gap before each request and of a
  // stall on each result cycle.
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count    = 0;

  // Model state: records held for the current set, and the sorted results
  // still owed by the block, oldest first.
  rec_t     held_recs[$];
  rms_out_t pending_sorted[$];

  record_merge_sort_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Take one accepted request into the model. Hold the record while there is
  // room and drop it once the store is full. On the closing request, order
  // the held records by key with a stable insertion: a record goes behind
  // every record whose key is equal to or below its own, so equal keys keep
  // their load order. Then queue one result per record and mark the last.
  function automatic void absorb_record(input rms_in_t req);
    rec_t ordered[$];
    rec_t rec;
    int   pos;
    if (held_recs.size() < STORE_DEPTH) begin
      rec.key = req.key;
      rec.tag = req.tag;
      held_recs.push_back(rec);
    end
    if (req.last) begin
      foreach (held_recs[i]) begin
        pos = ordered.size();
        while (pos > 0 && ordered[pos-1].key > held_recs[i].key) pos--;
        ordered.insert(pos, held_recs[i]);
      end
      foreach (ordered[i]) begin
        pending_sorted.push_back('{sorted_key: ordered[i].key,
                                   sorted_tag: ordered[i].tag,
                                   final_res:  (i == ordered.size() - 1)});
      end
      held_recs.delete();
    end
  endfunction

  // Present one request from a falling edge, after a random gap, and hold it
  // until the block takes it. Return at the next falling edge.
  task automatic send_record(input logic [KEY_BITS-1:0] key,
                             input logic [TAG_BITS-1:0] tag,
                             input logic last);
    rms_in_t req;
    req.key  = key;
    req.tag  = tag;
    req.last = last;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (!in_ready);
    absorb_record(req);
    @(negedge clk);
  endtask

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      error_count++;
    end
  endfunction

  // Stall the result channel at random; change only on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every accepted result with the oldest one still owed.
  always @(posedge clk) begin
    rms_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sorted.size() == 0) begin
        $display("%0t: result with nothing owed: key %0h tag %0h final %0b",
                 $time, out_data.sorted_key, out_data.sorted_tag, out_data.final_res);
        error_count++;
      end else begin
        want = pending_sorted.pop_front();
        check_field("sorted_key", want.sorted_key, out_data.sorted_key);
        check_field("sorted_tag", want.sorted_tag, out_data.sorted_tag);
        check_field("final_res", want.final_res, out_data.final_res);
      end
    end
  end

  // Drive every key and tag bit both ways within one set, out of order.
  task automatic test_field_extremes();
    send_record(16'hFFFF, 8'h00, 1'b0);
    send_record(16'h0000, 8'hFF, 1'b0);
    send_record(16'h8000, 8'hAA, 1'b0);
    send_record(16'h7FFF, 8'h55, 1'b1);
  endtask

  // A set of one record: the only result is also the final one.
  task automatic test_single_record();
    send_record(16'h1234, 8'h5A, 1'b1);
  endtask

  // Equal keys must come out in load order, split by a smaller key.
  task automatic test_equal_keys();
    send_record(16'h0042, 8'h01, 1'b0);
    send_record(16'h0042, 8'h02, 1'b0);
    send_record(16'h0010, 8'h03, 1'b0);
    send_record(16'h0042, 8'h04, 1'b1);
  endtask

  // Fill the store in falling key order, with seven pairs of ties, then send a
  // closing request that finds the store full. Its key of zero ties the lowest
  // stored key and would come second if it were kept, so a wrongly stored record shows at once.
  task automatic test_store_full();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      send_record(KEY_BITS'((STORE_DEPTH - i) & ~1), TAG_BITS'(i), 1'b0);
    end
    send_record(16'h0000, 8'hEE, 1'b1);
  endtask

  // Random sets until about n_reqs requests have gone: mostly sizes that fit
  // the store, one in eight overfull, keys drawn narrow, extreme or wide.
  task automatic test_random_sets(input int unsigned n_reqs);
    int unsigned          sent;
    int unsigned          set_len;
    key_spread_t          spread;
    logic [KEY_BITS-1:0]  key;
    sent = 0;
    while (sent < n_reqs) begin
      set_len = ($urandom_range(7) == 0) ? $urandom_range(STORE_DEPTH + 8, STORE_DEPTH + 1)
                                         : $urandom_range(STORE_DEPTH, 1);
      spread  = key_spread_t'($urandom_range(2));
      for (int i = 0; i < set_len; i++) begin
        case (spread)
          KEYS_NARROW:  key = KEY_BITS'($urandom_range(7));
          KEYS_EXTREME: key = $urandom_range(1) ? '1 : '0;
          default:      key = KEY_BITS'($urandom);
        endcase
        send_record(key, TAG_BITS'($urandom), (i == set_len - 1));
      end
      sent += set_len;
    end
  endtask

  initial begin
    // Hold reset from the start, then release it on a falling edge.
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // First phase: gappy sender, heavily stalled receiver.
    send_gap_pct   = 34;
    recv_stall_pct = 47;
    test_field_extremes();
    test_single_record();
    test_equal_keys();
    test_store_full();
    test_random_sets(100);

    // Swap the idle rates.
    send_gap_pct   = 47;
    recv_stall_pct = 34;
    test_random_sets(100);

    // Run flat out on both sides.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_sets(100);

    in_valid = 1'b0;
    // Drain everything still owed, then hold a while to catch stray results.
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== record_merge_sort_core.f =====
rtl/rms_pkg.sv
rtl/rms_ram.sv
rtl/rms_ctrl.sv
rtl/rms_dp.sv
rtl/record_merge_sort_core.sv
bench/testbench.sv
